// ===== sv/als_pkg.sv =====
// Shared types and constants for the angle/length sweep sequencer.
// No dependencies; every module of the block imports this package.
package als_pkg;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] start_angle;
    logic signed [15:0] start_length;
    logic               start_clockwise;
  } als_req_t;

  typedef struct packed {
    logic signed [15:0] angle_cmd;
    logic signed [15:0] length_cmd;
    logic               static_flag;
    logic               done_res;
  } als_rsp_t;

  typedef struct packed {
    logic signed [15:0] min_angle;
    logic signed [15:0] max_angle;
    logic signed [15:0] min_length;
    logic [11:0]        angle_step;
    logic [13:0]        row_length_step;
    logic [13:0]        shorten_increment;
    logic [15:0]        measure_ticks;
    logic [15:0]        cycle_ticks;
  } als_cfg_t;

  typedef struct packed {
    logic signed [15:0] angle_now;
    logic signed [15:0] length_now;
    logic signed [15:0] length_target;
    logic               clockwise;
    logic               shortening;
    logic               running;
  } als_state_t;

  // status of the counter modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } als_mod_stat_t;

  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CFG_MIN_ANGLE         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ANGLE         = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE_STEP        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROW_LENGTH_STEP   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SHORTEN_INCREMENT = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MEASURE_TICKS     = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_CYCLE_TICKS       = 3'd7;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam als_cfg_t CFG_RESET = '{
    min_angle:         16'sd0,
    max_angle:         16'sd12868,
    min_length:        16'sd0,
    angle_step:        12'd41,
    row_length_step:   14'd164,
    shorten_increment: 14'd16,
    measure_ticks:     16'd0,
    cycle_ticks:       16'd1
  };

endpackage

// ===== sv/als_mod.sv =====
// Sequential remainder unit for the tick counter: one quotient bit per cycle.
// Depends on als_pkg for the status struct.
module als_mod
  import als_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [15:0]   value,
  input  logic [15:0]   divisor,
  output als_mod_stat_t stat,
  output logic [15:0]   rem
);

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [15:0] val;
  logic [15:0] div;
  logic [16:0] trial;
  logic [15:0] rem_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem, val[15]};
    if (trial >= {1'b0, div}) begin
      rem_next = 16'(trial - {1'b0, div});
    end else begin
      rem_next = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        val  <= value;
        div  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        val <= {val[14:0], 1'b0};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("modulo unit did not go busy after start");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy && !done)
    else $error("modulo unit restarted while a remainder was pending");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) done |-> rem < div)
    else $error("modulo unit remainder not below divisor");

endmodule

// ===== sv/als_step.sv =====
// Next-state and result logic for one sweep transaction (tick or load).
// Depends on als_pkg for the request, result, config and state types.
module als_step
  import als_pkg::*;
(
  input  als_cfg_t   cfg,
  input  als_state_t st,
  input  logic [15:0] tick_count,
  input  als_req_t   req,
  output als_state_t st_next,
  output als_rsp_t   rsp,
  output logic       tick_adv
);

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic               at_min_eq;
  logic               at_min;
  logic               at_max;
  logic               len_le_min;
  logic               len_lt_min;
  logic signed [17:0] short_sum;
  logic signed [17:0] row_sum;
  logic signed [17:0] ang_sum;
  logic               held;

  assign at_min_eq  = (st.angle_now == cfg.min_angle);
  assign at_min     = (st.angle_now <= cfg.min_angle);
  assign at_max     = (st.angle_now >= cfg.max_angle);
  assign len_le_min = (st.length_now <= cfg.min_length);
  assign len_lt_min = (st.length_now < cfg.min_length);

  assign short_sum = {{2{st.length_now[15]}}, st.length_now}
                   - $signed({4'b0, cfg.shorten_increment});
  assign row_sum   = {{2{st.length_now[15]}}, st.length_now}
                   - $signed({4'b0, cfg.row_length_step});
  assign ang_sum   = st.clockwise
                   ? {{2{st.angle_now[15]}}, st.angle_now} + $signed({6'b0, cfg.angle_step})
                   : {{2{st.angle_now[15]}}, st.angle_now} - $signed({6'b0, cfg.angle_step});

  always_comb begin
    st_next  = st;
    held     = 1'b1;
    tick_adv = 1'b0;
    if (req.req_type == REQ_LOAD) begin
      st_next.angle_now  = req.start_angle;
      st_next.length_now = req.start_length;
      st_next.clockwise  = req.start_clockwise;
      st_next.shortening = 1'b0;
      st_next.running    = 1'b1;
    end else if (st.running) begin
      tick_adv = 1'b1;
      if (tick_count >= cfg.measure_ticks) begin
        held = 1'b0;
        if ((at_min_eq && !st.clockwise && len_le_min) || len_lt_min) begin
          // sweep complete
          held            = 1'b1;
          st_next.running = 1'b0;
        end else if (st.shortening) begin
          held = 1'b1;
          if (st.length_now >= st.length_target) begin
            st_next.length_now = sat16(short_sum);
          end else begin
            st_next.shortening = 1'b0;
          end
        end else if ((at_min && !st.clockwise) || (at_max && st.clockwise)) begin
          // reverse and begin shortening toward the next row
          st_next.clockwise     = !st.clockwise;
          st_next.length_target = sat16(row_sum);
          st_next.shortening    = 1'b1;
        end else begin
          st_next.angle_now = sat16(ang_sum);
        end
      end
    end
  end

  assign rsp.angle_cmd   = st_next.angle_now;
  assign rsp.length_cmd  = st_next.length_now;
  assign rsp.static_flag = held;
  assign rsp.done_res    = !st_next.running;

endmodule

// ===== sv/angle_length_sweep_sequencer.sv =====
// Top level of the angle/length sweep sequencer: config registers, sweep state,
// tick counter, output register with skid stage. Uses als_pkg, als_step, als_mod.
//
//   channel | signals                      | direction | transfer
//   req     | req_valid, req_stall, req    | in        | req_valid && !req_stall
//   rsp     | rsp_valid, rsp_stall, rsp    | out       | rsp_valid && !rsp_stall
//   cfg     | cfg_we, cfg_index, cfg_data  | in        | cfg_we
//
// One transaction per cycle while req_stall is low; its result is registered for rsp.
// The sweep state updates in the accept cycle, so the next tick may follow at once.
// When cycle_ticks was lowered to half the incremented counter or less, the counter wrap
// takes the serial remainder unit; req_stall stays high until it loads tick_count.
// rst (synchronous) restores the config defaults and clears state; no clearing pass.
// A stalled rsp parks one result in the skid stage; req_stall also rises when it is full.
module angle_length_sweep_sequencer
  import als_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  als_req_t            req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output als_rsp_t            rsp,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  als_cfg_t      cfg;
  als_state_t    st;
  als_state_t    st_next;
  logic [15:0]   tick_count;
  als_rsp_t      step_rsp;
  logic          tick_adv;
  logic          accept;
  logic [15:0]   tick_inc;
  logic [16:0]   tick_diff;
  logic          mod_start;
  als_mod_stat_t mod_stat;
  logic [15:0]   mod_rem;
  logic          out_valid;
  als_rsp_t      out_data;
  logic          skid_valid;
  als_rsp_t      skid_data;
  logic          out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_ANGLE:         cfg.min_angle         <= cfg_data;
        CFG_MAX_ANGLE:         cfg.max_angle         <= cfg_data;
        CFG_MIN_LENGTH:        cfg.min_length        <= cfg_data;
        CFG_ANGLE_STEP:        cfg.angle_step        <= cfg_data[11:0];
        CFG_ROW_LENGTH_STEP:   cfg.row_length_step   <= cfg_data[13:0];
        CFG_SHORTEN_INCREMENT: cfg.shorten_increment <= cfg_data[13:0];
        CFG_MEASURE_TICKS:     cfg.measure_ticks     <= cfg_data;
        CFG_CYCLE_TICKS:       cfg.cycle_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_stall = skid_valid | mod_stat.busy | mod_stat.done;
  assign accept    = req_valid & ~req_stall;

  als_step u_step (
    .cfg        (cfg),
    .st         (st),
    .tick_count (tick_count),
    .req        (req),
    .st_next    (st_next),
    .rsp        (step_rsp),
    .tick_adv   (tick_adv)
  );

  // counter wrap: the usual cases need at most one subtract
  assign tick_inc  = tick_count + 16'd1;
  assign tick_diff = {1'b0, tick_inc} - {1'b0, cfg.cycle_ticks};
  assign mod_start = accept && tick_adv && (cfg.cycle_ticks != 16'd0)
                  && (tick_inc >= cfg.cycle_ticks)
                  && ({1'b0, tick_inc} >= {cfg.cycle_ticks, 1'b0});

  als_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .value   (tick_inc),
    .divisor (cfg.cycle_ticks),
    .stat    (mod_stat),
    .rem     (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      tick_count <= '0;
    end else if (mod_stat.done) begin
      tick_count <= mod_rem;
    end else if (accept) begin
      st <= st_next;
      if (req.req_type == REQ_LOAD) begin
        tick_count <= '0;
      end else if (tick_adv && !mod_start) begin
        if (cfg.cycle_ticks == 16'd0 || tick_inc < cfg.cycle_ticks) begin
          tick_count <= tick_inc;
        end else begin
          tick_count <= tick_diff[15:0];
        end
      end
    end
  end

  // output register plus skid stage
  assign out_free = ~out_valid | ~rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= step_rsp;
      end
    end else if (accept) begin
      skid_data <= step_rsp;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_data;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no pending result");
  a_hold_while_wrap: assert property (@(posedge clk) disable iff (rst)
    mod_stat.busy |-> req_stall && !accept)
    else $error("request accepted while the counter wrap was pending");

endmodule
